@@ src/uri_dec_pkg.sv @@
`default_nettype none
package uri_dec_pkg;

  localparam int UNIT_W = 16;
  localparam int CP_W   = 21;
  localparam int MAX_RES = 3;

  typedef enum logic [2:0] {
    PH_NORMAL   = 3'd0,
    PH_LEAD_HI  = 3'd1,
    PH_LEAD_LO  = 3'd2,
    PH_CONT_PCT = 3'd3,
    PH_CONT_HI  = 3'd4,
    PH_CONT_LO  = 3'd5,
    PH_SWALLOW  = 3'd6
  } phase_t;

  localparam logic [UNIT_W-1:0] CHAR_PCT = 16'h0025;

  // reserved set kept escaped in whole-uri mode
  localparam logic [7:0] RSV_SEMI  = 8'h3B;
  localparam logic [7:0] RSV_SLASH = 8'h2F;
  localparam logic [7:0] RSV_QUES  = 8'h3F;
  localparam logic [7:0] RSV_COLON = 8'h3A;
  localparam logic [7:0] RSV_AT    = 8'h40;
  localparam logic [7:0] RSV_AMP   = 8'h26;
  localparam logic [7:0] RSV_EQ    = 8'h3D;
  localparam logic [7:0] RSV_PLUS  = 8'h2B;
  localparam logic [7:0] RSV_DOLL  = 8'h24;
  localparam logic [7:0] RSV_COMMA = 8'h2C;
  localparam logic [7:0] RSV_HASH  = 8'h23;

  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SUPP     = 21'h010000;
  localparam logic [CP_W-1:0] CP_MIN2     = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN3     = 21'h000800;
  localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00DFFF;
  localparam logic [UNIT_W-1:0] HI_SURR_BASE = 16'hD800;
  localparam logic [UNIT_W-1:0] LO_SURR_BASE = 16'hDC00;

  typedef struct packed {
    logic [1:0]                     cnt;
    logic [MAX_RES-1:0][UNIT_W-1:0] unit;
    logic                           end_mark;
    logic                           malformed;
  } dec_res_t;

  // {valid, value}
  function automatic logic [4:0] nibble_of(input logic [UNIT_W-1:0] c);
    logic [UNIT_W-1:0] t;
    t = 16'h0000;
    if (c inside {[16'h0030:16'h0039]}) begin
      t = c - 16'h0030;
      return {1'b1, t[3:0]};
    end else if (c inside {[16'h0061:16'h0066]}) begin
      t = c - 16'h0057;
      return {1'b1, t[3:0]};
    end else if (c inside {[16'h0041:16'h0046]}) begin
      t = c - 16'h0037;
      return {1'b1, t[3:0]};
    end
    return 5'b0_0000;
  endfunction

endpackage
`default_nettype wire

@@ src/uri_percent_utf8_decoder.sv @@
// URI percent decoder with UTF-8 reassembly, one UTF-16 code unit per beat.
// Input channel in_valid/in_ready carries in_code_unit and in_is_last, the
// mark on the final unit of a string. Output channel out_valid/out_ready
// carries out_unit, out_end_mark and out_malformed.
// cfg_wr_en/cfg_wr_data set component mode (1 after reset); write it only
// between strings while the block is idle.
// A unit accepted into the input register is decoded combinationally and
// loaded into the result buffer, which drives the output; the load waits
// while the result buffer has no room for it.
// Throughput: one unit per cycle while out_ready is high and each unit
// gives at most one result. A reserved character kept as its escape gives
// three beats and a surrogate pair two; the input register then holds the
// next unit while the result buffer drains.
// A malformed string stops producing results; its last unit gives one beat
// with out_malformed and out_end_mark set, and out_unit zero.
// Reset empties both registers and returns to plain text with component mode.
// When out_ready is low the result buffer holds its beats and one more unit
// waits in the input register before in_ready drops.
`default_nettype none
module uri_percent_utf8_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [uri_dec_pkg::UNIT_W-1:0] in_code_unit,
  input  wire logic                          in_is_last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [uri_dec_pkg::UNIT_W-1:0]     out_unit,
  output logic                               out_end_mark,
  output logic                               out_malformed
);
  import uri_dec_pkg::*;

  logic              vld_q;
  logic [UNIT_W-1:0] unit_q;
  logic              last_q;
  logic              can_load;
  logic              adv;
  dec_res_t          res;

  assign adv = vld_q && can_load;

  uri_dec_in_reg u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_code_unit (in_code_unit),
    .in_is_last   (in_is_last),
    .take         (adv),
    .vld_o        (vld_q),
    .unit_o       (unit_q),
    .last_o       (last_q)
  );

  uri_dec_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .adv         (adv),
    .unit_i      (unit_q),
    .last_i      (last_q),
    .res_o       (res)
  );

  uri_dec_out_buf u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (adv),
    .res_i         (res),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_unit      (out_unit),
    .out_end_mark  (out_end_mark),
    .out_malformed (out_malformed)
  );

endmodule
`default_nettype wire

@@ src/uri_dec_in_reg.sv @@
`default_nettype none
module uri_dec_in_reg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [uri_dec_pkg::UNIT_W-1:0] in_code_unit,
  input  wire logic                        in_is_last,
  input  wire logic                        take,
  output logic                             vld_o,
  output logic [uri_dec_pkg::UNIT_W-1:0]   unit_o,
  output logic                             last_o
);
  import uri_dec_pkg::*;

  logic              vld_r, vld_nxt;
  logic [UNIT_W-1:0] unit_r;
  logic              last_r;

  assign in_ready = !vld_r || take;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      unit_r <= in_code_unit;
      last_r <= in_is_last;
    end
  end

  assign vld_o  = vld_r;
  assign unit_o = unit_r;
  assign last_o = last_r;

endmodule
`default_nettype wire

@@ src/uri_dec_core.sv @@
`default_nettype none
module uri_dec_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_wr_data,
  input  wire logic                          adv,
  input  wire logic [uri_dec_pkg::UNIT_W-1:0] unit_i,
  input  wire logic                          last_i,
  output uri_dec_pkg::dec_res_t              res_o
);
  import uri_dec_pkg::*;

  logic              mode_r;
  phase_t            phase_r, phase_nxt;
  logic [UNIT_W-1:0] fchar_r, fchar_nxt;
  logic [3:0]        nib_r, nib_nxt;
  logic [2:0]        len_r, len_nxt;
  logic [1:0]        left_r, left_nxt;
  logic [CP_W-1:0]   acc_r, acc_nxt;

  logic [4:0]        nib;
  logic [7:0]        byte_v;
  logic [CP_W-1:0]   cp;
  logic [CP_W-1:0]   supp;
  logic              bad;
  logic              overlong;
  dec_res_t          res;

  assign nib    = nibble_of(unit_i);
  assign byte_v = {nib_r, nib[3:0]};
  assign cp     = {acc_r[CP_W-7:0], byte_v[5:0]};
  assign supp   = cp - CP_SUPP;

  always_comb begin
    overlong = ((len_r == SEQ_LEN2) && (cp < CP_MIN2)) ||
               ((len_r == SEQ_LEN3) && (cp < CP_MIN3)) ||
               ((len_r == SEQ_LEN4) && (cp < CP_SUPP));
  end

  always_comb begin
    phase_nxt = phase_r;
    fchar_nxt = fchar_r;
    nib_nxt   = nib_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    acc_nxt   = acc_r;
    bad       = 1'b0;
    res       = '0;
    case (phase_r)
      PH_NORMAL: begin
        if (unit_i != CHAR_PCT) begin
          res.cnt     = 2'd1;
          res.unit[0] = unit_i;
        end else begin
          phase_nxt = PH_LEAD_HI;
        end
      end
      PH_LEAD_HI, PH_CONT_HI: begin
        if (!nib[4]) begin
          bad = 1'b1;
        end else begin
          nib_nxt = nib[3:0];
          if (phase_r == PH_LEAD_HI) begin
            fchar_nxt = unit_i;
            phase_nxt = PH_LEAD_LO;
          end else begin
            phase_nxt = PH_CONT_LO;
          end
        end
      end
      PH_LEAD_LO: begin
        if (!nib[4]) begin
          bad = 1'b1;
        end else if (!byte_v[7]) begin
          phase_nxt = PH_NORMAL;
          if (!mode_r && (byte_v inside {RSV_SEMI, RSV_SLASH, RSV_QUES, RSV_COLON,
                                         RSV_AT, RSV_AMP, RSV_EQ, RSV_PLUS,
                                         RSV_DOLL, RSV_COMMA, RSV_HASH})) begin
            res.cnt     = 2'd3;
            res.unit[0] = CHAR_PCT;
            res.unit[1] = fchar_r;
            res.unit[2] = unit_i;
          end else begin
            res.cnt     = 2'd1;
            res.unit[0] = {8'h00, byte_v};
          end
        end else if (byte_v[7:5] == 3'b110) begin
          len_nxt   = SEQ_LEN2;
          left_nxt  = 2'd1;
          acc_nxt   = {16'h0000, byte_v[4:0]};
          phase_nxt = PH_CONT_PCT;
        end else if (byte_v[7:4] == 4'b1110) begin
          len_nxt   = SEQ_LEN3;
          left_nxt  = 2'd2;
          acc_nxt   = {17'h00000, byte_v[3:0]};
          phase_nxt = PH_CONT_PCT;
        end else if (byte_v[7:3] == 5'b11110) begin
          len_nxt   = SEQ_LEN4;
          left_nxt  = 2'd3;
          acc_nxt   = {18'h00000, byte_v[2:0]};
          phase_nxt = PH_CONT_PCT;
        end else begin
          bad = 1'b1;
        end
      end
      PH_CONT_PCT: begin
        if (unit_i != CHAR_PCT) begin
          bad = 1'b1;
        end else begin
          phase_nxt = PH_CONT_HI;
        end
      end
      PH_CONT_LO: begin
        if (!nib[4] || (byte_v[7:6] != 2'b10)) begin
          bad = 1'b1;
        end else begin
          acc_nxt  = cp;
          left_nxt = left_r - 2'd1;
          if (left_r != 2'd1) begin
            phase_nxt = PH_CONT_PCT;
          end else if (overlong || (cp > CP_MAX) ||
                       ((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI))) begin
            bad = 1'b1;
          end else begin
            phase_nxt = PH_NORMAL;
            if (cp < CP_SUPP) begin
              res.cnt     = 2'd1;
              res.unit[0] = cp[UNIT_W-1:0];
            end else begin
              // surrogate pair from the 20-bit offset
              res.cnt     = 2'd2;
              res.unit[0] = HI_SURR_BASE + {6'd0, supp[19:10]};
              res.unit[1] = LO_SURR_BASE | {6'd0, supp[9:0]};
            end
          end
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    if (bad) begin
      res.cnt   = 2'd0;
      phase_nxt = PH_SWALLOW;
    end

    if (last_i) begin
      if ((phase_nxt != PH_NORMAL) || (res.cnt == 2'd0)) begin
        res.cnt       = 2'd1;
        res.unit      = '0;
        res.malformed = 1'b1;
      end
      res.end_mark = 1'b1;
      phase_nxt    = PH_NORMAL;
      fchar_nxt    = '0;
      nib_nxt      = '0;
      len_nxt      = '0;
      left_nxt     = '0;
      acc_nxt      = '0;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b1;
      phase_r <= PH_NORMAL;
      fchar_r <= '0;
      nib_r   <= '0;
      len_r   <= '0;
      left_r  <= '0;
      acc_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (adv) begin
        phase_r <= phase_nxt;
        fchar_r <= fchar_nxt;
        nib_r   <= nib_nxt;
        len_r   <= len_nxt;
        left_r  <= left_nxt;
        acc_r   <= acc_nxt;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/uri_dec_out_buf.sv @@
`default_nettype none
module uri_dec_out_buf (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire uri_dec_pkg::dec_res_t         res_i,
  output logic                               can_load,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [uri_dec_pkg::UNIT_W-1:0]     out_unit,
  output logic                               out_end_mark,
  output logic                               out_malformed
);
  import uri_dec_pkg::*;

  logic [1:0]                     cnt_r, cnt_nxt;
  logic [MAX_RES-1:0][UNIT_W-1:0] unit_r, unit_nxt;
  logic                           end_r, end_nxt;
  logic                           mal_r, mal_nxt;

  // room when empty, or when the last held beat leaves this cycle
  assign can_load  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign out_valid = (cnt_r != 2'd0);

  always_comb begin
    cnt_nxt  = cnt_r;
    unit_nxt = unit_r;
    end_nxt  = end_r;
    mal_nxt  = mal_r;
    if (load) begin
      cnt_nxt  = res_i.cnt;
      unit_nxt = res_i.unit;
      end_nxt  = res_i.end_mark;
      mal_nxt  = res_i.malformed;
    end else if (out_valid && out_ready) begin
      cnt_nxt     = cnt_r - 2'd1;
      unit_nxt[0] = unit_r[1];
      unit_nxt[1] = unit_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unit_r <= unit_nxt;
    end_r  <= end_nxt;
    mal_r  <= mal_nxt;
  end

  // flags belong to the final beat of the group
  assign out_unit      = unit_r[0];
  assign out_end_mark  = end_r && (cnt_r == 2'd1);
  assign out_malformed = mal_r && (cnt_r == 2'd1);

endmodule
`default_nettype wire

@@ src/uri_dec_checker.sv @@
`default_nettype none
module uri_dec_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic [uri_dec_pkg::UNIT_W-1:0] out_unit,
  input  wire logic                          out_end_mark,
  input  wire logic                          out_malformed
);
  import uri_dec_pkg::*;

  // a stalled beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_unit) &&
                                $stable(out_end_mark) && $stable(out_malformed))
    else $error("stalled output beat changed");

  // the error beat closes the string
  a_mal_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_malformed |-> out_end_mark)
    else $error("malformed beat without end mark");

  a_mal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_malformed |-> out_unit == '0)
    else $error("malformed beat with nonzero unit");

  // two register stages before any result can appear
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid ##1 (!out_valid || $past(in_valid && in_ready, 2)))
    else $error("result appeared too soon after reset");

endmodule

bind uri_percent_utf8_decoder uri_dec_checker u_uri_dec_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_unit      (out_unit),
  .out_end_mark  (out_end_mark),
  .out_malformed (out_malformed)
);
`default_nettype wire

@@ tb/uri_percent_utf8_decoder_tb.sv @@
module uri_percent_utf8_decoder_tb;
  import uri_dec_pkg::*;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              end_mark;
    logic              malformed;
  } unit_res_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic              cfg_wr_data = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [UNIT_W-1:0] in_code_unit = '0;
  logic              in_is_last = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [UNIT_W-1:0] out_unit;
  logic              out_end_mark;
  logic              out_malformed;

  // decoder state as the block should hold it
  phase_t            dec_phase = PH_NORMAL;
  logic [UNIT_W-1:0] hi_char = '0;
  logic [3:0]        hi_nib = '0;
  logic [2:0]        seq_len = '0;
  logic [1:0]        left = '0;
  logic [CP_W-1:0]   cp_acc = '0;
  logic              comp_mode = 1'b1;

  unit_res_t         step_out[$];
  unit_res_t         want_units[$];
  logic [UNIT_W-1:0] text_q[$];

  int snd_idle = 0;
  int rcv_idle = 0;
  int hold_len = 0;
  int errors = 0;
  int units_in = 0;
  int strings_in = 0;
  int beats_checked = 0;
  int strings_bad = 0;
  int mode_writes = 0;

  uri_percent_utf8_decoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_code_unit (in_code_unit),
    .in_is_last   (in_is_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_unit     (out_unit),
    .out_end_mark (out_end_mark),
    .out_malformed(out_malformed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic [4:0] hex_digit_val(input logic [UNIT_W-1:0] c);
    if (c >= 16'h0030 && c <= 16'h0039) return {1'b1, c[3:0]};
    // letters: low nibble of 'A' and 'a' is 1
    if ((c >= 16'h0041 && c <= 16'h0046) || (c >= 16'h0061 && c <= 16'h0066))
      return {1'b1, c[3:0] + 4'd9};
    return 5'b0_0000;
  endfunction

  function automatic logic is_reserved_byte(input logic [7:0] b);
    case (b)
      RSV_SEMI, RSV_SLASH, RSV_QUES, RSV_COLON, RSV_AT, RSV_AMP, RSV_EQ,
      RSV_PLUS, RSV_DOLL, RSV_COMMA, RSV_HASH: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic emit(input logic [UNIT_W-1:0] u);
    unit_res_t r;
    r = {u, 1'b0, 1'b0};
    step_out.insert(step_out.size(), r);
  endtask

  task automatic decode_unit(input logic [UNIT_W-1:0] cu, input logic last);
    logic [4:0]      d;
    logic [7:0]      b;
    logic            bad;
    logic [CP_W-1:0] v;
    unit_res_t       r;
    bad = 1'b0;
    step_out.delete();
    case (dec_phase)
      PH_NORMAL: begin
        if (cu != CHAR_PCT) emit(cu);
        else dec_phase = PH_LEAD_HI;
      end
      PH_LEAD_HI, PH_CONT_HI: begin
        d = hex_digit_val(cu);
        if (!d[4]) begin
          bad = 1'b1;
        end else begin
          hi_nib = d[3:0];
          if (dec_phase == PH_LEAD_HI) begin
            hi_char = cu;
            dec_phase = PH_LEAD_LO;
          end else begin
            dec_phase = PH_CONT_LO;
          end
        end
      end
      PH_LEAD_LO: begin
        d = hex_digit_val(cu);
        if (!d[4]) begin
          bad = 1'b1;
        end else begin
          b = {hi_nib, d[3:0]};
          if (!b[7]) begin
            if (!comp_mode && is_reserved_byte(b)) begin
              emit(CHAR_PCT);
              emit(hi_char);
              emit(cu);
            end else begin
              emit({8'h00, b});
            end
            dec_phase = PH_NORMAL;
          end else begin
            if (b[7:5] == 3'b110) begin
              seq_len = SEQ_LEN2;
              cp_acc = {16'h0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
              seq_len = SEQ_LEN3;
              cp_acc = {17'h0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
              seq_len = SEQ_LEN4;
              cp_acc = {18'h0, b[2:0]};
            end else begin
              bad = 1'b1;
            end
            if (!bad) begin
              left = seq_len[1:0] - 2'd1;
              dec_phase = PH_CONT_PCT;
            end
          end
        end
      end
      PH_CONT_PCT: begin
        if (cu != CHAR_PCT) bad = 1'b1;
        else dec_phase = PH_CONT_HI;
      end
      PH_CONT_LO: begin
        d = hex_digit_val(cu);
        b = {hi_nib, d[3:0]};
        if (!d[4] || b[7:6] != 2'b10) begin
          bad = 1'b1;
        end else begin
          cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
          left = left - 2'd1;
          if (left != 2'd0) begin
            dec_phase = PH_CONT_PCT;
          end else if ((seq_len == SEQ_LEN2 && cp_acc < CP_MIN2) ||
                       (seq_len == SEQ_LEN3 && cp_acc < CP_MIN3) ||
                       (seq_len == SEQ_LEN4 && cp_acc < CP_SUPP) ||
                       cp_acc > CP_MAX ||
                       (cp_acc >= CP_SURR_LO && cp_acc <= CP_SURR_HI)) begin
            bad = 1'b1;
          end else begin
            if (cp_acc < CP_SUPP) begin
              emit(cp_acc[UNIT_W-1:0]);
            end else begin
              v = cp_acc - CP_SUPP;
              emit(HI_SURR_BASE + {6'h0, v[19:10]});
              emit(LO_SURR_BASE + {6'h0, v[9:0]});
            end
            dec_phase = PH_NORMAL;
          end
        end
      end
      default: bad = 1'b1;
    endcase

    if (bad) begin
      step_out.delete();
      dec_phase = PH_SWALLOW;
    end
    if (last) begin
      if (dec_phase != PH_NORMAL || step_out.size() == 0) begin
        step_out.delete();
        r = {16'h0000, 1'b1, 1'b1};
        step_out.insert(0, r);
      end else begin
        r = step_out[step_out.size() - 1];
        r.end_mark = 1'b1;
        step_out[step_out.size() - 1] = r;
      end
      dec_phase = PH_NORMAL;
      hi_char = '0;
      hi_nib = '0;
      seq_len = '0;
      left = '0;
      cp_acc = '0;
      strings_in++;
    end
    foreach (step_out[i]) want_units.insert(want_units.size(), step_out[i]);
  endtask

  task automatic check_beat();
    unit_res_t want;
    if (want_units.size() == 0) begin
      if (errors < 10)
        $display("beat %0d: unit %h end %b bad %b with nothing outstanding",
                 beats_checked, out_unit, out_end_mark, out_malformed);
      errors++;
    end else begin
      want = want_units.pop_front();
      if ({out_unit, out_end_mark, out_malformed} !== want) begin
        if (errors < 10)
          $display("beat %0d: expected unit %h end %b bad %b, got unit %h end %b bad %b",
                   beats_checked, want.unit, want.end_mark, want.malformed,
                   out_unit, out_end_mark, out_malformed);
        errors++;
      end
      if (want.malformed) strings_bad++;
    end
    beats_checked++;
  endtask

  // accepted units are predicted before the same edge's result is checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        decode_unit(in_code_unit, in_is_last);
        units_in++;
      end
      if (out_valid && out_ready) check_beat();
    end
  end

  // result side: random stalls, or a long hold-off counted here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rcv_idle);
      end
    end
  end

  // ---------------------------------------------------------------- driving

  task automatic send_unit(input logic [UNIT_W-1:0] cu, input logic last);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(0, 99) < snd_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_code_unit <= cu;
    in_is_last <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_unit(text_q[i], i == text_q.size() - 1);
  endtask

  // stop offering and let every outstanding beat drain, plus pipeline slack
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (want_units.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    comp_mode = m;
    mode_writes++;
  endtask

  // ---------------------------------------------------------------- text building

  task automatic put_text(input logic [UNIT_W-1:0] u);
    text_q.insert(text_q.size(), u);
  endtask

  task automatic add_hex(input logic [3:0] n);
    if (n < 4'd10)
      put_text(16'h0030 + n);
    else
      put_text(($urandom_range(0, 1) ? 16'h0040 : 16'h0060) + n - 16'd9);
  endtask

  task automatic add_esc(input logic [7:0] b);
    put_text(CHAR_PCT);
    add_hex(b[7:4]);
    add_hex(b[3:0]);
  endtask

  // utf-8 of cp in exactly len bytes: overlong and out of range forms too
  task automatic add_utf8(input logic [CP_W-1:0] cp, input int len);
    case (len)
      2: begin
        add_esc({3'b110, cp[10:6]});
      end
      3: begin
        add_esc({4'b1110, cp[15:12]});
        add_esc({2'b10, cp[11:6]});
      end
      default: begin
        add_esc({5'b11110, cp[20:18]});
        add_esc({2'b10, cp[17:12]});
        add_esc({2'b10, cp[11:6]});
      end
    endcase
    add_esc({2'b10, cp[5:0]});
  endtask

  function automatic logic [7:0] pick_reserved();
    case ($urandom_range(0, 10))
      0: return RSV_SEMI;
      1: return RSV_SLASH;
      2: return RSV_QUES;
      3: return RSV_COLON;
      4: return RSV_AT;
      5: return RSV_AMP;
      6: return RSV_EQ;
      7: return RSV_PLUS;
      8: return RSV_DOLL;
      9: return RSV_COMMA;
      default: return RSV_HASH;
    endcase
  endfunction

  // neighbours of the hex ranges, or a digit with high bits set
  function automatic logic [UNIT_W-1:0] bad_hex_char();
    case ($urandom_range(0, 6))
      0: return 16'h002F;
      1: return 16'h003A;
      2: return 16'h0040;
      3: return 16'h0047;
      4: return 16'h0060;
      5: return 16'h0067;
      default: return 16'h0031 + ($urandom_range(1, 255) << 8);
    endcase
  endfunction

  task automatic add_token();
    logic [UNIT_W-1:0] u;
    logic [CP_W-1:0]   cp;
    case ($urandom_range(0, 9))
      0, 1: begin
        u = $urandom_range(16'h0020, 16'h007E);
        if (u == CHAR_PCT) u = 16'h007E;
        put_text(u);
      end
      2: begin
        u = $urandom_range(0, 16'hFFFF);
        if (u == CHAR_PCT) u = 16'hFFFF;
        put_text(u);
      end
      3: add_esc(pick_reserved());
      4: add_esc($urandom_range(0, 8'h7F));
      5: add_utf8($urandom_range(21'h80, 21'h7FF), 2);
      6, 7: begin
        cp = $urandom_range(21'h800, 21'hFFFF);
        if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) cp = cp ^ 21'h004000;
        add_utf8(cp, 3);
      end
      default: add_utf8($urandom_range(21'h10000, 21'h10FFFF), 4);
    endcase
  endtask

  task automatic add_fault();
    int len;
    case ($urandom_range(0, 7))
      0: begin
        put_text(CHAR_PCT);
        if ($urandom_range(0, 1)) add_hex($urandom_range(0, 15));
        put_text(bad_hex_char());
      end
      1: add_esc($urandom_range(0, 1) ? $urandom_range(8'h80, 8'hBF)
                                      : $urandom_range(8'hF8, 8'hFF));
      2: begin
        // continuation missing its percent sign
        add_esc(8'hC3);
        put_text(16'h0038);
      end
      3: begin
        add_esc(8'hE2);
        add_esc($urandom_range(0, 1) ? $urandom_range(0, 8'h7F)
                                     : $urandom_range(8'hC0, 8'hFF));
      end
      4: begin
        len = $urandom_range(2, 4);
        add_utf8(len == 2 ? $urandom_range(0, 21'h7F) :
                 len == 3 ? $urandom_range(0, 21'h7FF) : $urandom_range(0, 21'hFFFF), len);
      end
      5: add_utf8($urandom_range(CP_SURR_LO, CP_SURR_HI), 3);
      6: add_utf8($urandom_range(21'h110000, 21'h1FFFFF), 4);
      default: begin
        add_esc(8'hC3);
        put_text(CHAR_PCT);
        put_text(bad_hex_char());
      end
    endcase
  endtask

  // mostly well-formed strings; some broken, some cut off inside an escape
  task automatic build_string();
    int r;
    text_q.delete();
    repeat ($urandom_range(1, 5)) add_token();
    r = $urandom_range(0, 99);
    if (r < 20) begin
      add_fault();
      repeat ($urandom_range(0, 2)) add_token();
    end else if (r < 28) begin
      case ($urandom_range(0, 2))
        0: put_text(CHAR_PCT);
        1: begin
          put_text(CHAR_PCT);
          add_hex($urandom_range(0, 15));
        end
        default: begin
          add_esc(8'hF0);
          add_esc(8'h9F);
          put_text(CHAR_PCT);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- tests

  // runs on the reset value of component mode
  task automatic test_plain_extremes();
    text_q = '{16'h0000, 16'hFFFF};
    send_text();
    // highest code point, mixed-case hex, surrogate pair out
    text_q = '{CHAR_PCT, 16'h0066, 16'h0034, CHAR_PCT, 16'h0038, 16'h0046,
               CHAR_PCT, 16'h0062, 16'h0066, CHAR_PCT, 16'h0042, 16'h0046};
    send_text();
  endtask

  task automatic test_whole_uri_reserved();
    set_mode(1'b0);
    text_q = '{CHAR_PCT, 16'h0032, 16'h0066};
    send_text();
  endtask

  task automatic test_malformed_directed();
    // string ending right after the percent sign
    text_q = '{CHAR_PCT};
    send_text();
    text_q = '{CHAR_PCT, 16'h0047};
    send_text();
    // lone continuation byte as a lead
    text_q = '{CHAR_PCT, 16'h0038, 16'h0030};
    send_text();
  endtask

  task automatic test_random_strings(input int snd, input int rcv, input int n,
                                     input logic first_mode);
    int sent;
    int since_cfg;
    sent = 0;
    since_cfg = 0;
    snd_idle = snd;
    rcv_idle = rcv;
    set_mode(first_mode);
    while (sent < n) begin
      if (since_cfg >= 32) begin
        set_mode($urandom_range(0, 1));
        since_cfg = 0;
      end
      build_string();
      send_text();
      sent += text_q.size();
      since_cfg += text_q.size();
    end
  endtask

  // long result stall while units keep coming: the block must back up
  task automatic test_receiver_hold();
    int sent;
    sent = 0;
    snd_idle = 0;
    rcv_idle = 0;
    wait_idle();
    @(negedge clk);
    hold_len = 60;
    @(posedge clk);
    while (sent < 30) begin
      build_string();
      send_text();
      sent += text_q.size();
    end
    wait_idle();
  endtask

  // sender drains everything halfway through a four-byte escape
  task automatic test_pause_mid_string();
    snd_idle = 20;
    rcv_idle = 20;
    text_q.delete();
    add_utf8($urandom_range(21'h10000, 21'h10FFFF), 4);
    add_token();
    foreach (text_q[i]) begin
      if (i == 6) wait_idle();
      send_unit(text_q[i], i == text_q.size() - 1);
    end
  endtask

  initial begin
    int guard;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_plain_extremes();
    test_whole_uri_reserved();
    test_malformed_directed();
    test_random_strings(33, 45, 75, 1'b0);
    test_random_strings(45, 33, 75, 1'b1);
    test_random_strings(0, 0, 60, 1'b0);
    test_receiver_hold();
    test_pause_mid_string();

    in_valid <= 1'b0;
    guard = 0;
    while (want_units.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (want_units.size() != 0) begin
      $display("%0d decoded units never arrived", want_units.size());
      errors += want_units.size();
    end

    $display("%0d code units in %0d strings, %0d beats checked, %0d strings flagged malformed",
             units_in, strings_in, beats_checked, strings_bad);
    $display("component mode written %0d times, %0d bad beats", mode_writes, errors);
    if (errors == 0) begin
      $display("uri_percent_utf8_decoder: match");
    end else begin
      $display("uri_percent_utf8_decoder: mismatch");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("uri_percent_utf8_decoder: mismatch");
    $finish;
  end

endmodule
